FILE: sv/ohlc_pkg.sv
package ohlc_pkg;
  localparam int TsW = 52;
  localparam int PxW = 32;
  localparam int AccW = 64;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStart = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEnd = 2'd2;
  localparam logic [TsW-1:0] PeriodReset = 52'd60000000;
  localparam logic [TsW-1:0] EndReset = {TsW{1'b1}};
  localparam int InW = TsW + 2 * PxW;
  localparam int InBytesW = ((InW + 7) / 8) * 8;
  localparam int OutW = TsW + 7 * PxW + 1;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;

  // classified request handed from front to back
  typedef struct packed {
    logic           finish;
    logic [TsW-1:0] ts;
    logic [PxW-1:0] bid;
    logic [PxW-1:0] spread;
  } req_t;

  typedef struct packed {
    logic [TsW-1:0] open_time;
    logic [PxW-1:0] open_p;
    logic [PxW-1:0] high_p;
    logic [PxW-1:0] low_p;
    logic [PxW-1:0] close_p;
    logic [PxW-1:0] total;
    logic [PxW-1:0] mean;
    logic [PxW-1:0] peak;
    logic           closed;
  } bar_t;
endpackage

FILE: sv/ohlc_divider.sv
// Restoring divider, one quotient bit per cycle.
module ohlc_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ohlc_pkg::AccW-1:0] dividend,
  input  logic [ohlc_pkg::AccW-1:0] divisor,
  output logic                    done,
  output logic [ohlc_pkg::AccW-1:0] quotient,
  output logic [ohlc_pkg::AccW-1:0] remainder
);
  import ohlc_pkg::*;
  localparam int CntW = $clog2(AccW + 1);
  logic [AccW-1:0] rem, quo, dvs;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [AccW:0] shifted, diff;

  always_comb begin
    shifted = {rem, quo[AccW-1]};
    diff = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CntW'(AccW);
    end else if (busy) begin
      if (!diff[AccW]) begin
        rem <= diff[AccW-1:0];
        quo <= {quo[AccW-2:0], 1'b1};
      end else begin
        rem <= shifted[AccW-1:0];
        quo <= {quo[AccW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      done <= (cnt == CntW'(1));
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end
  assign quotient = quo;
  assign remainder = rem;
endmodule

FILE: sv/ohlc_front.sv
// Accepts items, drops ticks outside [start, end) and all items if start >= end, queues the rest (two entries).
module ohlc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ohlc_pkg::req_t         in_req,
  input  logic [ohlc_pkg::TsW-1:0] start_time,
  input  logic [ohlc_pkg::TsW-1:0] end_time,
  output logic                   q_valid,
  input  logic                   q_ready,
  output ohlc_pkg::req_t         q_req
);
  import ohlc_pkg::*;
  req_t slot [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  logic keep, push, pop;

  always_comb begin
    keep = (start_time < end_time) &&
           (in_req.finish || (in_req.ts >= start_time && in_req.ts < end_time));
    in_ready = (cnt != 2'd2);
    push = in_valid && in_ready && keep;
    q_valid = (cnt != 2'd0);
    pop = q_valid && q_ready;
    q_req = slot[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wr_ptr] <= in_req;
    end
  end
endmodule

FILE: sv/ohlc_back.sv
// Bucket math and bar state; the shared divider does floor and mean.
module ohlc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  ohlc_pkg::req_t         q_req,
  input  logic [ohlc_pkg::TsW-1:0] period_us,
  input  logic [ohlc_pkg::TsW-1:0] end_time,
  output logic                   bar_valid,
  input  logic                   bar_ready,
  output ohlc_pkg::bar_t         bar
);
  import ohlc_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_BDIV, S_MDIV, S_EMIT, S_UPD
  } state_t;
  state_t state;
  req_t cur;
  logic [TsW-1:0] per, bucket, bucket_start;
  logic [AccW-1:0] quo_r, accum;
  logic active, closed_r;
  logic [PxW-1:0] first_bid, max_bid, min_bid, last_bid, tcount, smax;
  logic dv_start, dv_done;
  logic [AccW-1:0] dv_a, dv_b, dv_q, dv_r;
  logic [TsW:0] end_chk;

  ohlc_divider u_div (
    .clk, .rst, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  always_comb begin
    q_ready = (state == S_IDLE);
    dv_start = 1'b0;
    dv_a = {{(AccW-TsW){1'b0}}, cur.ts};
    dv_b = {{(AccW-TsW){1'b0}}, per};
    if (state == S_IDLE && q_valid && !q_req.finish) begin
      dv_start = 1'b1;
      dv_a = {{(AccW-TsW){1'b0}}, q_req.ts};
      dv_b = {{(AccW-TsW){1'b0}}, (period_us == '0) ? TsW'(1) : period_us};
    end else if (state == S_UPD && active && bucket != bucket_start) begin
      dv_start = 1'b1;
      dv_a = accum;
      dv_b = {{(AccW-PxW){1'b0}}, tcount};
    end else if (state == S_IDLE && q_valid && q_req.finish && active) begin
      dv_start = 1'b1;
      dv_a = accum;
      dv_b = {{(AccW-PxW){1'b0}}, tcount};
    end
    end_chk = {1'b0, bucket_start} + {1'b0, (period_us == '0) ? TsW'(1) : period_us};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= 1'b0;
      bar_valid <= 1'b0;
    end else begin
      if (bar_valid && bar_ready) begin
        bar_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_req;
          per <= (period_us == '0) ? TsW'(1) : period_us;
          if (!q_req.finish) begin
            state <= S_BDIV;
          end else if (active) begin
            closed_r <= (end_chk <= {1'b0, end_time});
            state <= S_MDIV;
          end
        end
        // bucket = ts minus (ts mod period)
        S_BDIV: if (dv_done) begin
          bucket <= cur.ts - dv_r[TsW-1:0];
          state <= S_UPD;
        end
        S_UPD: begin
          if (active && bucket != bucket_start) begin
            closed_r <= 1'b1;
            state <= S_MDIV;
          end else begin
            if (!active) begin
              active <= 1'b1;
              bucket_start <= bucket;
              first_bid <= cur.bid;
              max_bid <= cur.bid;
              min_bid <= cur.bid;
              last_bid <= cur.bid;
              tcount <= PxW'(1);
              accum <= {{(AccW-PxW){1'b0}}, cur.spread};
              smax <= cur.spread;
            end else begin
              if (cur.bid > max_bid) max_bid <= cur.bid;
              if (cur.bid < min_bid) min_bid <= cur.bid;
              last_bid <= cur.bid;
              if (tcount != '1) begin
                tcount <= tcount + 1'b1;
                accum <= accum + {{(AccW-PxW){1'b0}}, cur.spread};
              end
              if (cur.spread > smax) smax <= cur.spread;
            end
            state <= S_IDLE;
          end
        end
        S_MDIV: if (dv_done) begin
          quo_r <= dv_q;
          state <= S_EMIT;
        end
        S_EMIT: if (!bar_valid) begin
          bar_valid <= 1'b1;
          bar.open_time <= bucket_start;
          bar.open_p <= first_bid;
          bar.high_p <= max_bid;
          bar.low_p <= min_bid;
          bar.close_p <= last_bid;
          bar.total <= tcount;
          bar.mean <= (quo_r[AccW-1:PxW] != '0) ? '1 : quo_r[PxW-1:0];
          bar.peak <= smax;
          bar.closed <= closed_r;
          active <= 1'b0;
          // a tick that closed the bar now opens the next one
          state <= cur.finish ? S_IDLE : S_UPD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/tick_to_ohlc_bar_aggregator_unit.sv
// Flow: a tick is taken, its bucket is found by a division by the period, then
//   the bar is updated; one that closes a bar also waits for a second division
//   for the mean and for the bar to be emitted before the next bar opens.
// Throughput: one item at a time in the back end, bounded by the shared
//   radix-2 divider; a two-entry queue lets the input run ahead.
// Reset: synchronous rst clears control and loads register defaults.
module tick_to_ohlc_bar_aggregator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: timestamp_us, bid_points, spread_points, zero fill
  input  logic [ohlc_pkg::InBytesW-1:0] s_tdata,
  // tuser: func
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: bar_open_time, open, high, low, close, tick_total,
  //   spread_mean, spread_peak, bar_closed, zero fill
  output logic [ohlc_pkg::OutBytesW-1:0] m_tdata,
  input  logic        cfg_we,
  input  logic [ohlc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ohlc_pkg::TsW-1:0] cfg_data
);
  import ohlc_pkg::*;
  logic [TsW-1:0] period_us, start_time, end_time;
  req_t in_req, q_req;
  bar_t bar;
  logic q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_us <= PeriodReset;
      start_time <= '0;
      end_time <= EndReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPeriod: period_us <= cfg_data;
        RegStart: start_time <= cfg_data;
        RegEnd: end_time <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_req = '{finish: s_tuser, ts: s_tdata[TsW-1:0],
                    bid: s_tdata[TsW+PxW-1:TsW], spread: s_tdata[TsW+2*PxW-1:TsW+PxW]};

  ohlc_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
    .start_time, .end_time, .q_valid, .q_ready, .q_req
  );

  ohlc_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req, .period_us, .end_time,
    .bar_valid(m_tvalid), .bar_ready(m_tready), .bar
  );

  assign m_tdata = {{(OutBytesW-OutW){1'b0}}, bar.closed, bar.peak, bar.mean,
                    bar.total, bar.close_p, bar.low_p, bar.high_p, bar.open_p,
                    bar.open_time};
endmodule
